@@ design/fba_pkg.sv @@
`timescale 1ns / 1ps

package fba_pkg;

    localparam int MAX_FRAMES_DEF = 4096;
    localparam int WORD_BITS      = 32;
    localparam int BIT_IDX_W      = 5;
    localparam int FRAME_W        = 12;
    localparam int CFG_W          = 13;
    localparam int STATUS_W       = 3;

    localparam logic [CFG_W-1:0] FRAME_COUNT_RST = 13'd4096;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOCATED = 3'd0,
        ST_HAD_FRAME = 3'd1,
        ST_NO_FRAME  = 3'd2,
        ST_FREED     = 3'd3,
        ST_NOTHING   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE_RD,
        S_FREE_WR,
        S_DONE
    } t_state;

endpackage

@@ design/frame_bitmap_allocator.sv @@
`timescale 1ns / 1ps

// Channel    Direction  Handshake          Payload
// request    in         i_valid/o_ready    i_opcode, i_page_frame, i_is_kernel, i_writable
// result     out        o_valid/i_ready    o_new_frame, o_present_bit, o_rw_bit, o_user_bit,
//                                          o_status
// config     in         i_cfg_we           i_cfg_wdata (frame_count)
//
// One request at a time. Allocation reads one bitmap word per cycle from the memory
// read port and tests each word while fetching the next; the lowest clear bit found is
// set and its frame returned. A free reads the word, then writes it with the bit clear.
// After reset a clearing pass writes MAX_FRAMES/32 words with o_ready low. A stalled
// result sits in the output register; the next request is taken meanwhile and its
// result waits until the register is free.

module frame_bitmap_allocator #(
    parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [fba_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_opcode,
    input  logic [fba_pkg::FRAME_W-1:0]  i_page_frame,
    input  logic                         i_is_kernel,
    input  logic                         i_writable,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [fba_pkg::FRAME_W-1:0]  o_new_frame,
    output logic                         o_present_bit,
    output logic                         o_rw_bit,
    output logic                         o_user_bit,
    output logic [fba_pkg::STATUS_W-1:0] o_status
);
    import fba_pkg::*;

    localparam int NWORDS = MAX_FRAMES / WORD_BITS;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    // Counter width: must hold NWORDS itself and frame_count/32
    localparam int CW     = (AW + 1 > CFG_W - BIT_IDX_W) ? AW + 1 : CFG_W - BIT_IDX_W;
    localparam logic [CW-1:0] NWORDS_C = CW'(NWORDS);
    localparam logic [CW-1:0] LAST_C   = CW'(NWORDS - 1);

    // Bitmap memory, one port each way
    logic [WORD_BITS-1:0] r_bitmap [NWORDS];
    logic [WORD_BITS-1:0] r_rdata;
    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata;

    // Sequencer state
    t_state               r_state, n_state;
    logic [CW-1:0]        r_word, n_word;
    logic                 r_chk_valid, n_chk_valid;
    logic [AW-1:0]        r_chk_addr, n_chk_addr;
    logic [CFG_W-1:0]     r_frame_count;

    // Latched request
    logic [FRAME_W-1:0]   r_pf, n_pf;
    logic                 r_kern, n_kern;
    logic                 r_wr, n_wr;

    // Pending result and output register
    logic [FRAME_W-1:0]   r_res_frame, n_res_frame;
    logic                 r_res_pr, n_res_pr;
    logic                 r_res_rw, n_res_rw;
    logic                 r_res_us, n_res_us;
    t_status              r_res_st, n_res_st;

    logic                 r_out_valid, n_out_valid;
    logic [FRAME_W-1:0]   r_out_frame, n_out_frame;
    logic                 r_out_pr, n_out_pr;
    logic                 r_out_rw, n_out_rw;
    logic                 r_out_us, n_out_us;
    t_status              r_out_st, n_out_st;

    // Word unit for the scan: lowest clear bit of the word under test
    logic [WORD_BITS-1:0] low_zero;
    logic [BIT_IDX_W-1:0] low_idx;
    logic                 word_full;
    logic [CW-1:0]        fc_words, scan_limit;
    logic [CW-1:0]        in_word;
    logic [AW-1:0]        free_addr;
    logic [WORD_BITS-1:0] free_mask;

    assign low_zero  = ~r_rdata & (r_rdata + WORD_BITS'(1));
    assign word_full = (low_zero == '0);

    always_comb begin
        low_idx = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            for (int b = 0; b < BIT_IDX_W; b++) begin
                if (((i >> b) & 1) == 1) begin
                    low_idx[b] = low_idx[b] | low_zero[i];
                end
            end
        end
    end

    // Scan covers whole words below frame_count, clamped to the words that exist
    assign fc_words   = CW'(r_frame_count[CFG_W-1:BIT_IDX_W]);
    assign scan_limit = (fc_words > NWORDS_C) ? NWORDS_C : fc_words;

    assign in_word   = CW'(i_page_frame[FRAME_W-1:BIT_IDX_W]);
    assign free_addr = AW'(r_pf[FRAME_W-1:BIT_IDX_W]);
    assign free_mask = ~(WORD_BITS'(1) << r_pf[BIT_IDX_W-1:0]);

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_word      = r_word;
        n_chk_valid = r_chk_valid;
        n_chk_addr  = r_chk_addr;
        n_pf        = r_pf;
        n_kern      = r_kern;
        n_wr        = r_wr;
        n_res_frame = r_res_frame;
        n_res_pr    = r_res_pr;
        n_res_rw    = r_res_rw;
        n_res_us    = r_res_us;
        n_res_st    = r_res_st;
        n_out_valid = r_out_valid && !i_ready;
        n_out_frame = r_out_frame;
        n_out_pr    = r_out_pr;
        n_out_rw    = r_out_rw;
        n_out_us    = r_out_us;
        n_out_st    = r_out_st;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = '0;
        mem_raddr   = '0;
        mem_wdata   = '0;

        unique case (r_state)
            S_CLEAR: begin
                // Sweep the bitmap to all free, one word a cycle
                mem_we    = 1'b1;
                mem_waddr = r_word[AW-1:0];
                mem_wdata = '0;
                if (r_word == LAST_C) begin
                    n_word  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_word = r_word + CW'(1);
                end
            end

            S_IDLE: begin
                if (i_valid) begin
                    n_pf        = i_page_frame;
                    n_kern      = i_is_kernel;
                    n_wr        = i_writable;
                    n_res_frame = '0;
                    n_res_pr    = 1'b0;
                    n_res_rw    = 1'b0;
                    n_res_us    = 1'b0;
                    unique case (t_opcode'(i_opcode))
                        OP_ALLOC: begin
                            if (i_page_frame != '0) begin
                                n_res_frame = i_page_frame;
                                n_res_st    = ST_HAD_FRAME;
                                n_state     = S_DONE;
                            end else begin
                                n_word      = '0;
                                n_chk_valid = 1'b0;
                                n_state     = S_SCAN;
                            end
                        end
                        OP_FREE: begin
                            if (i_page_frame == '0) begin
                                n_res_st = ST_NOTHING;
                                n_state  = S_DONE;
                            end else begin
                                n_res_st = ST_FREED;
                                // Drop frees that fall beyond the bitmap
                                n_state  = (in_word < NWORDS_C) ? S_FREE_RD : S_DONE;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end

            S_SCAN: begin
                // Test the word read last cycle while fetching the next one
                if (r_chk_valid && !word_full) begin
                    mem_we      = 1'b1;
                    mem_waddr   = r_chk_addr;
                    mem_wdata   = r_rdata | low_zero;
                    n_res_frame = FRAME_W'({r_chk_addr, low_idx});
                    n_res_pr    = 1'b1;
                    n_res_rw    = r_wr;
                    n_res_us    = ~r_kern;
                    n_res_st    = ST_ALLOCATED;
                    n_state     = S_DONE;
                end else if (r_word < scan_limit) begin
                    mem_re      = 1'b1;
                    mem_raddr   = r_word[AW-1:0];
                    n_chk_addr  = r_word[AW-1:0];
                    n_chk_valid = 1'b1;
                    n_word      = r_word + CW'(1);
                end else begin
                    n_res_st = ST_NO_FRAME;
                    n_state  = S_DONE;
                end
            end

            S_FREE_RD: begin
                mem_re    = 1'b1;
                mem_raddr = free_addr;
                n_state   = S_FREE_WR;
            end

            S_FREE_WR: begin
                mem_we    = 1'b1;
                mem_waddr = free_addr;
                mem_wdata = r_rdata & free_mask;
                n_state   = S_DONE;
            end

            S_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_frame = r_res_frame;
                    n_out_pr    = r_res_pr;
                    n_out_rw    = r_res_rw;
                    n_out_us    = r_res_us;
                    n_out_st    = r_res_st;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_bitmap[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_bitmap[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_word        <= '0;
            r_chk_valid   <= 1'b0;
            r_out_valid   <= 1'b0;
            r_frame_count <= FRAME_COUNT_RST;
        end else begin
            r_state     <= n_state;
            r_word      <= n_word;
            r_chk_valid <= n_chk_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_frame_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_addr  <= n_chk_addr;
        r_pf        <= n_pf;
        r_kern      <= n_kern;
        r_wr        <= n_wr;
        r_res_frame <= n_res_frame;
        r_res_pr    <= n_res_pr;
        r_res_rw    <= n_res_rw;
        r_res_us    <= n_res_us;
        r_res_st    <= n_res_st;
        r_out_frame <= n_out_frame;
        r_out_pr    <= n_out_pr;
        r_out_rw    <= n_out_rw;
        r_out_us    <= n_out_us;
        r_out_st    <= n_out_st;
    end

    assign o_valid       = r_out_valid;
    assign o_new_frame   = r_out_frame;
    assign o_present_bit = r_out_pr;
    assign o_rw_bit      = r_out_rw;
    assign o_user_bit    = r_out_us;
    assign o_status      = r_out_st;

endmodule

@@ design/fba_checker.sv @@
`timescale 1ns / 1ps

module fba_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [fba_pkg::FRAME_W-1:0]  o_new_frame,
    input logic                         o_present_bit,
    input logic                         o_rw_bit,
    input logic                         o_user_bit,
    input logic [fba_pkg::STATUS_W-1:0] o_status
);
    import fba_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_new_frame) && $stable(o_status))
        else $error("result changed while stalled");

    // Only one request in flight
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request taken while busy");

    // Present flag only on a successful allocation
    a_present_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_present_bit |-> o_status == ST_ALLOCATED)
        else $error("present set without allocation");

    // Failed or free results carry no frame and no flags
    a_free_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_NO_FRAME || o_status == ST_FREED
                    || o_status == ST_NOTHING)
        |-> o_new_frame == '0 && !o_present_bit && !o_rw_bit && !o_user_bit)
        else $error("stray fields on non-allocating result");

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_new_frame   (o_new_frame),
    .o_present_bit (o_present_bit),
    .o_rw_bit      (o_rw_bit),
    .o_user_bit    (o_user_bit),
    .o_status      (o_status)
);

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import fba_pkg::*;

    // Request and page-entry update as the block sees them.
    typedef struct packed {
        t_opcode              op;
        logic [FRAME_W-1:0]   page_frame;
        logic                 is_kernel;
        logic                 writable;
    } t_frame_req;

    typedef struct packed {
        logic [FRAME_W-1:0]   new_frame;
        logic                 present_bit;
        logic                 rw_bit;
        logic                 user_bit;
        t_status              status;
    } t_page_entry;

    localparam int MAP_WORDS = MAX_FRAMES_DEF / WORD_BITS;

    // Clock, reset and every block input start at a known value.
    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_cfg_we     = 1'b0;
    logic [CFG_W-1:0]    i_cfg_wdata  = '0;
    logic                i_valid      = 1'b0;
    logic                i_opcode     = 1'b0;
    logic [FRAME_W-1:0]  i_page_frame = '0;
    logic                i_is_kernel  = 1'b0;
    logic                i_writable   = 1'b0;
    logic                i_ready      = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic [FRAME_W-1:0]  o_new_frame;
    logic                o_present_bit;
    logic                o_rw_bit;
    logic                o_user_bit;
    logic [STATUS_W-1:0] o_status;

    // Shadow of the frame bitmap and of frame_count, updated in transfer order.
    bit   [WORD_BITS-1:0] frame_map_model [MAP_WORDS];
    logic [CFG_W-1:0]     frame_count_model = FRAME_COUNT_RST;

    t_frame_req  pending_req_q [$];   // requests not yet offered to the block
    t_page_entry page_entry_q  [$];   // predicted page-entry updates, oldest first
    t_frame_req  next_req;
    int          error_count = 0;

    // Sender burst shaping and receiver stall pattern.
    int burst_left = 0;
    int gap_left   = 0;
    int ready_run  = 0;
    int stall_run  = 0;

    always #1 i_clk = ~i_clk;

    frame_bitmap_allocator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_page_frame  (i_page_frame),
        .i_is_kernel   (i_is_kernel),
        .i_writable    (i_writable),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_new_frame   (o_new_frame),
        .o_present_bit (o_present_bit),
        .o_rw_bit      (o_rw_bit),
        .o_user_bit    (o_user_bit),
        .o_status      (o_status)
    );

    // Work out the page-entry update for one request and advance the shadow bitmap.
    function automatic t_page_entry predict_frame_request(input t_frame_req req);
        t_page_entry res;
        int unsigned limit;
        int unsigned frame;
        bit          found;
        res.new_frame   = '0;
        res.present_bit = 1'b0;
        res.rw_bit      = 1'b0;
        res.user_bit    = 1'b0;
        res.status      = ST_NOTHING;
        found           = 1'b0;
        frame           = 0;
        if (req.op == OP_ALLOC) begin
            if (req.page_frame != '0) begin
                res.new_frame = req.page_frame;
                res.status    = ST_HAD_FRAME;
            end else begin
                // Scan whole words only; clamp an oversized count to the map.
                limit = frame_count_model / WORD_BITS;
                if (limit > MAP_WORDS)
                    limit = MAP_WORDS;
                for (int w = 0; w < limit && !found; w++) begin
                    for (int b = 0; b < WORD_BITS && !found; b++) begin
                        if (!frame_map_model[w][b]) begin
                            found = 1'b1;
                            frame = w * WORD_BITS + b;
                        end
                    end
                end
                if (found) begin
                    frame_map_model[frame / WORD_BITS][frame % WORD_BITS] = 1'b1;
                    res.new_frame   = frame[FRAME_W-1:0];
                    res.present_bit = 1'b1;
                    res.rw_bit      = req.writable;
                    res.user_bit    = ~req.is_kernel;
                    res.status      = ST_ALLOCATED;
                end else begin
                    res.status = ST_NO_FRAME;
                end
            end
        end else if (req.page_frame != '0) begin
            // Clear the bit even when the frame lies above frame_count.
            frame_map_model[req.page_frame / WORD_BITS][req.page_frame % WORD_BITS] = 1'b0;
            res.status = ST_FREED;
        end
        return res;
    endfunction

    // Driver: predict on each transfer, then offer the next pending request in bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                page_entry_q.push_back(predict_frame_request(
                    '{op: t_opcode'(i_opcode), page_frame: i_page_frame,
                      is_kernel: i_is_kernel, writable: i_writable}));
            end
            // Only touch valid when the channel is free after this edge.
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_req_q.size() > 0) begin
                    next_req = pending_req_q.pop_front();
                    i_valid      <= 1'b1;
                    i_opcode     <= next_req.op;
                    i_page_frame <= next_req.page_frame;
                    i_is_kernel  <= next_req.is_kernel;
                    i_writable   <= next_req.writable;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                                 : $urandom_range(0, 8);
                        gap_left   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 16);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall on its own pattern and check every result transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (page_entry_q.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    error_count++;
                end else begin
                    automatic t_page_entry exp_entry = page_entry_q.pop_front();
                    if (o_new_frame !== exp_entry.new_frame) begin
                        $error("new_frame expected %0d got %0d", exp_entry.new_frame,
                               o_new_frame);
                        error_count++;
                    end
                    if (o_present_bit !== exp_entry.present_bit) begin
                        $error("present_bit expected %0d got %0d", exp_entry.present_bit,
                               o_present_bit);
                        error_count++;
                    end
                    if (o_rw_bit !== exp_entry.rw_bit) begin
                        $error("rw_bit expected %0d got %0d", exp_entry.rw_bit, o_rw_bit);
                        error_count++;
                    end
                    if (o_user_bit !== exp_entry.user_bit) begin
                        $error("user_bit expected %0d got %0d", exp_entry.user_bit,
                               o_user_bit);
                        error_count++;
                    end
                    if (o_status !== exp_entry.status) begin
                        $error("status expected %0d got %0d", exp_entry.status, o_status);
                        error_count++;
                    end
                end
            end
            if (ready_run > 0) begin
                ready_run--;
                i_ready <= 1'b1;
            end else if (stall_run > 0) begin
                stall_run--;
                i_ready <= 1'b0;
            end else begin
                ready_run = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                        : $urandom_range(1, 24);
                stall_run = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                i_ready <= 1'b1;
            end
        end
    end

    task automatic push_req(input t_opcode op, input int pf, input int kern, input int wr);
        pending_req_q.push_back('{op: op, page_frame: pf[FRAME_W-1:0],
                                  is_kernel: kern[0], writable: wr[0]});
    endtask

    // Hold until every request is offered, taken and answered; sample on the
    // falling edge so that all updates of the rising edge have settled.
    task automatic drain_requests();
        while (pending_req_q.size() != 0 || i_valid || page_entry_q.size() != 0)
            @(negedge i_clk);
        // Let the block settle back to idle.
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_frame_count(input logic [CFG_W-1:0] value);
        drain_requests();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        frame_count_model = value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Random mix: mostly allocations and frees of frames likely in use, some
    // pages that already hold a frame, and some frees of zero or of any frame.
    task automatic random_requests(input int count, input int span, input int alloc_pct);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < alloc_pct) begin
                if ($urandom_range(0, 99) < 12)
                    push_req(OP_ALLOC, $urandom_range(1, 4095), $urandom_range(0, 1),
                             $urandom_range(0, 1));
                else
                    push_req(OP_ALLOC, 0, $urandom_range(0, 1), $urandom_range(0, 1));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    push_req(OP_FREE, 0, $urandom_range(0, 1), $urandom_range(0, 1));
                else if (pick < 18)
                    push_req(OP_FREE, $urandom_range(0, 4095), $urandom_range(0, 1),
                             $urandom_range(0, 1));
                else
                    push_req(OP_FREE, $urandom_range(0, span), $urandom_range(0, 1),
                             $urandom_range(0, 1));
            end
        end
    endtask

    initial begin
        int unsigned phase_counts [9];
        int          span;
        int          alloc_pct;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Hold off until the clearing pass after reset is over.
        do @(negedge i_clk); while (!o_ready);

        // Directed: reset frame_count, both opcodes, every flag combination.
        push_req(OP_FREE,  0,    0, 0);   // nothing to free
        push_req(OP_FREE,  4095, 1, 1);   // free of a frame never handed out
        push_req(OP_ALLOC, 0,    0, 0);   // frame zero is handed out first
        push_req(OP_ALLOC, 0,    1, 1);
        push_req(OP_ALLOC, 0,    0, 1);
        push_req(OP_ALLOC, 0,    1, 0);
        push_req(OP_ALLOC, 4095, 1, 1);   // page already holds a frame
        push_req(OP_ALLOC, 1,    0, 0);
        push_req(OP_FREE,  2,    0, 0);
        push_req(OP_ALLOC, 0,    0, 1);   // the freed frame comes back
        push_req(OP_FREE,  0,    1, 1);   // frame zero cannot be given back
        push_req(OP_FREE,  3000, 0, 1);

        // No managed words: every allocation that needs a scan fails cleanly.
        write_frame_count('0);
        push_req(OP_ALLOC, 0,     1, 1);
        push_req(OP_ALLOC, 12'hAAA, 0, 1);
        push_req(OP_FREE,  12'h555, 1, 0);

        // Oversized count: scan clamps to the words that exist.
        write_frame_count({CFG_W{1'b1}});
        push_req(OP_ALLOC, 0, 1, 1);
        push_req(OP_ALLOC, 0, 0, 0);
        push_req(OP_FREE,  4, 0, 0);
        push_req(OP_ALLOC, 0, 1, 0);

        // Random phases; small counts exhaust the bitmap and exercise recovery.
        phase_counts = '{32, 64, 31, 100, 4096, 8191, 0, 160, 32};
        phase_counts[6] = $urandom_range(0, 8191);
        foreach (phase_counts[p]) begin
            write_frame_count(phase_counts[p][CFG_W-1:0]);
            if (phase_counts[p] > 256) begin
                span      = 400;
                alloc_pct = 70;
            end else begin
                span      = phase_counts[p] + 40;
                alloc_pct = 55;
            end
            random_requests(150, span, alloc_pct);
        end

        drain_requests();
        // Allow for one more full scan in case anything is still in flight.
        repeat (150) @(negedge i_clk);
        if (page_entry_q.size() != 0) begin
            $error("%0d page-entry updates never arrived", page_entry_q.size());
            error_count++;
        end
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
